@@ rtl/core/pdv_pkg.sv @@
package pdv_pkg;

   localparam int FRAC_BITS = 16;

   // quotient bits per division, one cell each; wide enough that a clamped
   // quotient still saturates the screen range after the origin is added
   localparam int QB = (FRAC_BITS + 17 > 33) ? FRAC_BITS + 17 : 33;
   localparam int REM_W = 33;
   localparam int PXY_W = 49;
   localparam int NUM_XW = PXY_W + FRAC_BITS;
   localparam int NUM_ZW = 51;
   localparam int SUM_W = QB + 2;
   localparam int DEPTH_W = 17;
   localparam logic [DEPTH_W-1:0] DEPTH_ONE = 17'h10000;

   localparam logic [2:0] CSR_LEFT = 3'd0;
   localparam logic [2:0] CSR_TOP = 3'd1;
   localparam logic [2:0] CSR_WIDTH = 3'd2;
   localparam logic [2:0] CSR_HEIGHT = 3'd3;
   localparam logic [2:0] CSR_NEAR = 3'd4;
   localparam logic [2:0] CSR_FAR = 3'd5;

   typedef struct packed {
      logic signed [14:0] left;
      logic signed [14:0] top;
      logic [14:0] width;
      logic [14:0] height;
      logic [DEPTH_W-1:0] near;
      logic [DEPTH_W-1:0] far;
   } cfg_type;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [QB-1:0] sh;
   } lane_type;

   typedef struct packed {
      logic [REM_W-1:0] d;
      logic negx;
      logic negy;
      logic negz;
      logic ovx;
      logic ovy;
      logic ovz;
      logic bad;
   } side_type;

   typedef struct packed {
      logic valid;
      side_type side;
      lane_type lx;
      lane_type ly;
      lane_type lz;
   } stage_type;

endpackage

@@ rtl/core/pdv_req_if.sv @@
interface pdv_req_if;
   logic valid;
   logic ready;
   logic signed [31:0] clip_x;
   logic signed [31:0] clip_y;
   logic signed [31:0] clip_z;
   logic signed [31:0] clip_w;
   modport source(output valid, clip_x, clip_y, clip_z, clip_w, input ready);
   modport sink(input valid, clip_x, clip_y, clip_z, clip_w, output ready);
endinterface

@@ rtl/core/pdv_rsp_if.sv @@
interface pdv_rsp_if;
   logic valid;
   logic ready;
   logic signed [31:0] screen_x;
   logic signed [31:0] screen_y;
   logic [16:0] depth_out;
   logic bad_w;
   modport source(output valid, screen_x, screen_y, depth_out, bad_w, input ready);
   modport sink(input valid, screen_x, screen_y, depth_out, bad_w, output ready);
endinterface

@@ rtl/core/pdv_front.sv @@
module pdv_front (
   input  logic clock,
   input  logic reset,
   pdv_req_if.sink req_ch,
   input  pdv_pkg::cfg_type cfg,
   output pdv_pkg::stage_type dn,
   input  logic dn_en
);
   logic v1_ff, v2_ff, en1, en2;
   logic signed [pdv_pkg::PXY_W-1:0] px_ff, px_in, py_ff, py_in;
   logic signed [pdv_pkg::NUM_ZW-1:0] pz_ff, pz_in;
   logic [pdv_pkg::REM_W-1:0] d_ff, d_in;
   logic bad1_ff, bad1_in;
   logic signed [32:0] xw, yw;
   logic signed [17:0] fn;
   logic signed [18:0] sp;
   logic signed [15:0] vw, vh;
   logic [pdv_pkg::NUM_XW-1:0] nx, ny, mx, my;
   logic [pdv_pkg::NUM_ZW-1:0] mz;
   pdv_pkg::stage_type st_ff, st_in;

   assign en2 = !v2_ff || dn_en;
   assign en1 = !v1_ff || en2;
   assign req_ch.ready = en1;

   // stage one: products
   always_comb begin
      xw = 33'(req_ch.clip_x) + 33'(req_ch.clip_w);
      yw = 33'(req_ch.clip_w) - 33'(req_ch.clip_y);
      vw = $signed({1'b0, cfg.width});
      vh = $signed({1'b0, cfg.height});
      fn = $signed({1'b0, cfg.far}) - $signed({1'b0, cfg.near});
      sp = $signed({2'b00, cfg.far} + {2'b00, cfg.near});
      px_in = pdv_pkg::PXY_W'(vw) * pdv_pkg::PXY_W'(xw);
      py_in = pdv_pkg::PXY_W'(vh) * pdv_pkg::PXY_W'(yw);
      pz_in = pdv_pkg::NUM_ZW'(fn) * pdv_pkg::NUM_ZW'(req_ch.clip_z)
            + pdv_pkg::NUM_ZW'(sp) * pdv_pkg::NUM_ZW'(req_ch.clip_w);
      bad1_in = (req_ch.clip_w[31] == 1'b1) || (req_ch.clip_w == 32'sd0);
      d_in = bad1_in ? pdv_pkg::REM_W'(1) : {req_ch.clip_w, 1'b0};
   end

   // stage two: floor via complement of negative numerators, overflow check
   always_comb begin
      nx = {px_ff, {pdv_pkg::FRAC_BITS{1'b0}}};
      ny = {py_ff, {pdv_pkg::FRAC_BITS{1'b0}}};
      mx = px_ff[pdv_pkg::PXY_W-1] ? ~nx : nx;
      my = py_ff[pdv_pkg::PXY_W-1] ? ~ny : ny;
      mz = pz_ff;
      st_in.valid = v1_ff;
      st_in.side.d = d_ff;
      st_in.side.bad = bad1_ff;
      st_in.side.negx = px_ff[pdv_pkg::PXY_W-1];
      st_in.side.negy = py_ff[pdv_pkg::PXY_W-1];
      st_in.side.negz = pz_ff[pdv_pkg::NUM_ZW-1];
      st_in.side.ovx = (mx >> pdv_pkg::QB) >= pdv_pkg::NUM_XW'(d_ff);
      st_in.side.ovy = (my >> pdv_pkg::QB) >= pdv_pkg::NUM_XW'(d_ff);
      st_in.side.ovz = (mz >> pdv_pkg::QB) >= pdv_pkg::NUM_ZW'(d_ff);
      st_in.lx.rem = pdv_pkg::REM_W'(mx >> pdv_pkg::QB);
      st_in.ly.rem = pdv_pkg::REM_W'(my >> pdv_pkg::QB);
      st_in.lz.rem = pdv_pkg::REM_W'(mz >> pdv_pkg::QB);
      st_in.lx.sh = mx[pdv_pkg::QB-1:0];
      st_in.ly.sh = my[pdv_pkg::QB-1:0];
      st_in.lz.sh = mz[pdv_pkg::QB-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_ch.valid;
         if (en2) v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         px_ff <= px_in;
         py_ff <= py_in;
         pz_ff <= pz_in;
         d_ff <= d_in;
         bad1_ff <= bad1_in;
      end
      if (en2) st_ff <= st_in;
   end

   always_comb begin
      dn = st_ff;
      dn.valid = v2_ff;
   end
endmodule

@@ rtl/core/pdv_cell.sv @@
module pdv_cell (
   input  logic clock,
   input  logic reset,
   input  pdv_pkg::stage_type up,
   output logic up_en,
   output pdv_pkg::stage_type dn,
   input  logic dn_en
);
   logic valid_ff;
   pdv_pkg::stage_type st_ff, st_in;

   // one restoring step: bring down the next numerator bit, keep quotient bit
   function automatic pdv_pkg::lane_type step(input pdv_pkg::lane_type l,
                                              input logic [pdv_pkg::REM_W-1:0] d);
      logic [pdv_pkg::REM_W:0] t;
      logic q;
      pdv_pkg::lane_type r;
      t = {l.rem, l.sh[pdv_pkg::QB-1]};
      q = t >= {1'b0, d};
      r.rem = q ? pdv_pkg::REM_W'(t - {1'b0, d}) : t[pdv_pkg::REM_W-1:0];
      r.sh = {l.sh[pdv_pkg::QB-2:0], q};
      return r;
   endfunction

   assign up_en = !valid_ff || dn_en;

   always_comb begin
      st_in = up;
      st_in.lx = step(up.lx, up.side.d);
      st_in.ly = step(up.ly, up.side.d);
      st_in.lz = step(up.lz, up.side.d);
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (up_en) valid_ff <= up.valid;
   end

   always_ff @(posedge clock) begin
      if (up_en) st_ff <= st_in;
   end

   always_comb begin
      dn = st_ff;
      dn.valid = valid_ff;
   end
endmodule

@@ rtl/core/pdv_back.sv @@
module pdv_back (
   input  logic clock,
   input  logic reset,
   input  pdv_pkg::stage_type up,
   output logic up_en,
   input  pdv_pkg::cfg_type cfg,
   pdv_rsp_if.source rsp_ch
);
   localparam logic signed [pdv_pkg::SUM_W-1:0] SMAX = pdv_pkg::SUM_W'(64'sh7fffffff);
   localparam logic signed [pdv_pkg::SUM_W-1:0] SMIN = pdv_pkg::SUM_W'(-64'sh80000000);

   logic valid_ff;
   logic signed [31:0] sx_ff, sx_in, sy_ff, sy_in;
   logic [pdv_pkg::DEPTH_W-1:0] dz_ff, dz_in;
   logic bad_ff;
   logic [pdv_pkg::QB-1:0] qx, qy, qz;
   logic signed [pdv_pkg::QB:0] vx, vy;
   logic signed [pdv_pkg::SUM_W-1:0] ax, ay;

   function automatic logic signed [31:0] sat(input logic signed [pdv_pkg::SUM_W-1:0] v);
      logic signed [31:0] r;
      if (v > SMAX) r = 32'sh7fffffff;
      else if (v < SMIN) r = -32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

   assign up_en = !valid_ff || rsp_ch.ready;

   always_comb begin
      qx = up.side.ovx ? '1 : up.lx.sh;
      qy = up.side.ovy ? '1 : up.ly.sh;
      qz = up.lz.sh;
      vx = up.side.negx ? ~$signed({1'b0, qx}) : $signed({1'b0, qx});
      vy = up.side.negy ? ~$signed({1'b0, qy}) : $signed({1'b0, qy});
      ax = pdv_pkg::SUM_W'(vx) + (pdv_pkg::SUM_W'(cfg.left) <<< pdv_pkg::FRAC_BITS);
      ay = pdv_pkg::SUM_W'(vy) + (pdv_pkg::SUM_W'(cfg.top) <<< pdv_pkg::FRAC_BITS);
      sx_in = sat(ax);
      sy_in = sat(ay);
      if (up.side.negz) dz_in = '0;
      else if (up.side.ovz || qz > pdv_pkg::QB'(pdv_pkg::DEPTH_ONE)) dz_in = pdv_pkg::DEPTH_ONE;
      else dz_in = qz[pdv_pkg::DEPTH_W-1:0];
      if (up.side.bad) begin
         sx_in = '0;
         sy_in = '0;
         dz_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (up_en) valid_ff <= up.valid;
   end

   always_ff @(posedge clock) begin
      if (up_en) begin
         sx_ff <= sx_in;
         sy_ff <= sy_in;
         dz_ff <= dz_in;
         bad_ff <= up.side.bad;
      end
   end

   assign rsp_ch.valid = valid_ff;
   assign rsp_ch.screen_x = sx_ff;
   assign rsp_ch.screen_y = sy_ff;
   assign rsp_ch.depth_out = dz_ff;
   assign rsp_ch.bad_w = bad_ff;
endmodule

@@ rtl/core/perspective_divide_viewport_unit.sv @@
// channel   dir  payload                                   handshake
// req_ch    in   clip_x, clip_y, clip_z, clip_w            valid/ready
// rsp_ch    out  screen_x, screen_y, depth_out, bad_w      valid/ready
// csr_*     in   csr_index, csr_wdata                      csr_we, no wait
//
// one word per cycle while rsp_ch.ready holds, through QB + 3 register stages:
// two front stages for products and overflow checks, one divider cell per
// quotient bit, one output register
// reset clears the valid bits and sets the configuration registers to their defaults
// each stage stalls only when it is full and its successor will not take
// its word, so bubbles close up behind a stalled output
module perspective_divide_viewport_unit (
   input  logic clock,
   input  logic reset,
   pdv_req_if.sink req_ch,
   pdv_rsp_if.source rsp_ch,
   input  logic csr_we,
   input  logic [2:0] csr_index,
   input  logic [16:0] csr_wdata
);
   pdv_pkg::cfg_type cfg_ff;
   pdv_pkg::stage_type chain [pdv_pkg::QB+1];
   logic en [pdv_pkg::QB+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.left <= '0;
         cfg_ff.top <= '0;
         cfg_ff.width <= '0;
         cfg_ff.height <= '0;
         cfg_ff.near <= '0;
         cfg_ff.far <= pdv_pkg::DEPTH_ONE;
      end else if (csr_we) begin
         unique case (csr_index)
            pdv_pkg::CSR_LEFT: cfg_ff.left <= $signed(csr_wdata[14:0]);
            pdv_pkg::CSR_TOP: cfg_ff.top <= $signed(csr_wdata[14:0]);
            pdv_pkg::CSR_WIDTH: cfg_ff.width <= csr_wdata[14:0];
            pdv_pkg::CSR_HEIGHT: cfg_ff.height <= csr_wdata[14:0];
            pdv_pkg::CSR_NEAR: cfg_ff.near <= csr_wdata;
            pdv_pkg::CSR_FAR: cfg_ff.far <= csr_wdata;
            default: ;
         endcase
      end
   end

   pdv_front u_front (
      .clock(clock),
      .reset(reset),
      .req_ch(req_ch),
      .cfg(cfg_ff),
      .dn(chain[0]),
      .dn_en(en[0])
   );

   for (genvar i = 0; i < pdv_pkg::QB; i++) begin : g_cell
      pdv_cell u_cell (
         .clock(clock),
         .reset(reset),
         .up(chain[i]),
         .up_en(en[i]),
         .dn(chain[i+1]),
         .dn_en(en[i+1])
      );
   end

   pdv_back u_back (
      .clock(clock),
      .reset(reset),
      .up(chain[pdv_pkg::QB]),
      .up_en(en[pdv_pkg::QB]),
      .cfg(cfg_ff),
      .rsp_ch(rsp_ch)
   );
endmodule
